// ===== hdl/aes_pkg.sv =====
// Package for the AES block cipher core: types, S-box tables and round functions.
// Used by the controller, the datapath and the top level.
`default_nettype none
package aes_pkg;

  localparam int MaxRoundsDefault = 14;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_EXP,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_start;  // load cipher key words, begin expansion
    logic key_step;   // produce the next round key word
    logic load;       // load input block with initial key added
    logic round;      // run one middle round
    logic last;       // run the final round into the output register
  } aes_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic key_done;
    logic round_last;  // next round is the final one
  } aes_sts_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // State byte i sits in bits 127-8i .. 120-8i; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
    end
    sub_bytes = r;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    int src;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        src = inv ? ((c + 4 - w) % 4) : ((c + w) % 4);
        r[127-8*(4*c+w) -: 8] = s[127-8*(4*src+w) -: 8];
      end
    end
    shift_rows = r;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k] = col[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int w = 0; w < 4; w++) begin
      if (inv) begin
        r[31-8*w -: 8] = me[w] ^ mb[(w+1)%4] ^ md[(w+2)%4] ^ m9[(w+3)%4];
      end else begin
        r[31-8*w -: 8] = m2[w] ^ m3[(w+1)%4] ^ a[(w+2)%4] ^ a[(w+3)%4];
      end
    end
    mix_col = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      r[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    end
    mix_columns = r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_ctrl.sv =====
// Controller state machine of the AES core: key expansion, round sequencing, handshake.
// Depends on aes_pkg.
`default_nettype none
module aes_ctrl import aes_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     keys_ready,
  input  wire aes_sts_t sts,
  output aes_cmd_t      cmd,
  output logic          key_set
);

  aes_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    key_set = 1'b0;
    case (state)
      ST_IDLE: begin
        // Keys are expanded before the input is taken, so the block stays put.
        if (in_valid) begin
          if (keys_ready) begin
            in_ready = 1'b1;
            cmd.load = 1'b1;
            state_next = ST_ROUND;
          end else begin
            cmd.key_start = 1'b1;
            state_next = ST_KEY_EXP;
          end
        end
      end
      ST_KEY_EXP: begin
        cmd.key_step = 1'b1;
        if (sts.key_done) begin
          key_set = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ROUND: begin
        if (sts.round_last) begin
          cmd.last = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.round = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_without_keys: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> keys_ready) else $error("transfer without round keys");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped before transfer");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
`endif

endmodule
`default_nettype wire

// ===== hdl/aes_dp.sv =====
// Datapath of the AES core: key expander, round key store, shared round unit, output register.
// Depends on aes_pkg.
`default_nettype none
module aes_dp import aes_pkg::*; #(
  parameter int MAX_ROUNDS = MaxRoundsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire aes_cmd_t     cmd,
  output aes_sts_t          sts,
  input  wire logic [255:0] cipher_key,
  input  wire logic [1:0]   key_length_mode,
  input  wire logic         req_type,
  input  wire logic [63:0]  data_hi,
  input  wire logic [63:0]  data_lo,
  output logic [63:0]       result_hi,
  output logic [63:0]       result_lo
);

  localparam int Slots = MAX_ROUNDS + 1;
  localparam int WordSlots = 4 * Slots;
  localparam int RW = $clog2(Slots);
  localparam int WW = $clog2(WordSlots + 1);

  // Round count and key length in words for the current mode; mode 3 acts as 256.
  logic [1:0] m;
  logic [3:0] nk;
  logic [RW-1:0] nr;
  logic [4:0] nr_raw;
  assign m = (key_length_mode == 2'd3) ? MODE_256 : key_length_mode;
  assign nk = 4'd4 + {1'b0, m, 1'b0};
  assign nr_raw = 5'd10 + {2'b0, m, 1'b0};
  assign nr = (nr_raw > 5'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : nr_raw[RW-1:0];

  // Key expansion: a window of the last nk words (up to eight), one new word per cycle.
  logic [31:0] win [8];
  logic [WW-1:0] widx;
  logic [3:0] phase;  // widx mod nk, from widx == nk on
  logic [7:0] rcon;
  logic [WW-1:0] total;
  logic [31:0] prev, wprev_nk, tword, nword;
  logic [127:0] row_acc;
  assign total = WW'(4 * (32'(nr) + 1));
  assign prev = win[3'(nk - 4'd1)];
  assign wprev_nk = win[0];

  always_comb begin
    tword = prev;
    if (phase == 4'd0) begin
      tword = sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && phase == 4'd4) begin
      tword = sub_word(prev);
    end
  end
  assign nword = wprev_nk ^ tword;

  logic [127:0] rk_mem [Slots];
  logic [31:0] cur_word;
  assign cur_word = (widx < WW'(nk)) ? win[widx[2:0]] : nword;

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
    end else if (cmd.key_start) begin
      for (int i = 0; i < 8; i++) begin
        win[i] <= cipher_key[255-32*i -: 32];
      end
      widx <= '0;
      phase <= '0;
      rcon <= RCON_FIRST;
    end else if (cmd.key_step && widx < total) begin
      row_acc <= {row_acc[95:0], cur_word};
      if (widx[1:0] == 2'd3) begin
        rk_mem[widx[WW-1:2]] <= {row_acc[95:0], cur_word};
      end
      widx <= widx + 1'b1;
      if (widx >= WW'(nk)) begin
        // Slide the window of the last nk words.
        for (int i = 0; i < 7; i++) begin
          win[i] <= (4'(i) == nk - 4'd1) ? nword : win[i+1];
        end
        win[7] <= nword;
        phase <= (phase == nk - 4'd1) ? 4'd0 : phase + 4'd1;
        if (phase == 4'd0) begin
          rcon <= xtime(rcon);
        end
      end
    end
  end

  assign sts.key_done = (widx == total);

  // Round sequencing with a registered round key read.
  logic [127:0] st, rk;
  logic [RW-1:0] rnd;
  logic [RW-1:0] ridx;
  logic inv;
  logic [127:0] din;
  assign din = {data_hi, data_lo};

  always_comb begin
    if (cmd.load) begin
      ridx = req_type ? nr - 1'b1 : RW'(1);
    end else begin
      ridx = inv ? rnd - 1'b1 : rnd + 1'b1;
    end
    if (cmd.round && ((!inv && rnd + 1'b1 == nr) || (inv && rnd == RW'(1)))) begin
      ridx = inv ? '0 : nr;
    end
  end

  logic [RW-1:0] rk0_idx;
  logic [127:0] rk0;
  assign rk0_idx = req_type ? nr : '0;
  assign rk0 = rk_mem[rk0_idx];

  always_ff @(posedge clk) begin
    rk <= rk_mem[ridx];
  end

  logic [127:0] fwd_t, inv_t, fwd_r, inv_r;
  assign fwd_t = shift_rows(sub_bytes(st, 1'b0), 1'b0);
  assign inv_t = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rk;
  assign fwd_r = mix_columns(fwd_t, 1'b0) ^ rk;
  assign inv_r = mix_columns(inv_t, 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st <= din ^ rk0;
      inv <= req_type;
      rnd <= req_type ? nr - 1'b1 : RW'(1);
    end else if (cmd.round) begin
      st <= inv ? inv_r : fwd_r;
      rnd <= inv ? rnd - 1'b1 : rnd + 1'b1;
    end
    if (cmd.last) begin
      {result_hi, result_lo} <= inv ? inv_t : (fwd_t ^ rk);
    end
  end

  assign sts.round_last = inv ? (rnd == '0) : (rnd == nr);

`ifndef NO_ASSERTIONS
  a_round_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> (rnd <= nr)) else $error("round index beyond round count");
  a_load_not_round: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(cmd.round || cmd.last || cmd.key_step)) else $error("conflicting commands");
  a_last_after_round: assert property (@(posedge clk) disable iff (rst)
    cmd.last |=> !cmd.round) else $error("round after final round");
`endif

endmodule
`default_nettype wire

// ===== hdl/aes_block_cipher_core.sv =====
// AES block cipher core, 128/192/256-bit keys, encrypt and decrypt.
// Use: write key words and key length through the write port while idle, then
// present blocks on the input channel (valid/ready) with req_type 0 to encrypt
// or 1 to decrypt; the result appears on the output channel (valid/ready).
// Any register write marks the round keys stale. The first block after that
// waits while the key expander produces one 32-bit word per cycle for the round
// key store: 44, 52 or 60 words for 128, 192 or 256-bit keys.
// A block is loaded with the first round key added in the cycle of its
// transfer, then runs one round per cycle on the shared round datapath:
// 10, 12 or 14 rounds. One block is in flight at a time; the next is taken
// after the result transfer. If the receiver stalls, the result register
// holds its value.
// Reset clears the controller and marks the round keys stale; registers reset
// to zero and key length 128.
`default_nettype none
module aes_block_cipher_core import aes_pkg::*; #(
  parameter int MAX_ROUNDS = MaxRoundsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [63:0] data_hi,
  input  wire logic [63:0] data_lo,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_hi,
  output logic [63:0]      result_lo
);

  logic [63:0] key_bits_0, key_bits_1, key_bits_2, key_bits_3;
  logic [1:0] key_length_mode;
  logic keys_ready, key_set;
  aes_cmd_t cmd;
  aes_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bits_0 <= '0;
      key_bits_1 <= '0;
      key_bits_2 <= '0;
      key_bits_3 <= '0;
      key_length_mode <= MODE_128;
      keys_ready <= 1'b0;
    end else begin
      if (key_set) begin
        keys_ready <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0: begin key_bits_0 <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY1: begin key_bits_1 <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY2: begin key_bits_2 <= cfg_data; keys_ready <= 1'b0; end
          REG_KEY3: begin key_bits_3 <= cfg_data; keys_ready <= 1'b0; end
          REG_MODE: begin key_length_mode <= cfg_data[1:0]; keys_ready <= 1'b0; end
          default: ;
        endcase
      end
    end
  end

  aes_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .keys_ready, .sts, .cmd, .key_set
  );

  aes_dp #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .cipher_key({key_bits_0, key_bits_1, key_bits_2, key_bits_3}),
    .key_length_mode, .req_type, .data_hi, .data_lo, .result_hi, .result_lo
  );

`ifndef NO_ASSERTIONS
  a_cfg_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index <= REG_MODE) |=> !keys_ready) else $error("stale round keys");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_aes_block_cipher_core.sv =====
// Testbench for the AES block cipher core: known-answer rows, then random blocks
// under changing keys, key lengths and handshake pressure, checked by an AES model.
// Depends on aes_pkg (register and mode codes, S-box constants) and the core RTL.
module tb_aes_block_cipher_core;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_KEY0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_ENCRYPT;
  logic [63:0] data_hi = '0;
  logic [63:0] data_lo = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  aes_block_cipher_core dut (.*);

  always #1 clk = ~clk;

  // Shadow of the core's registers and round keys.
  logic [63:0]  key_reg [4];
  logic [1:0]   mode_reg;
  logic [127:0] round_key [15];
  bit           round_keys_valid;

  logic [127:0] pending_results [$];
  int           mismatches = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           hold_requests = 0;

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  function automatic int rounds_for_mode();
    return (mode_reg == MODE_UNUSED) ? 14 : 10 + 2 * mode_reg;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    int nk, total;
    nk = rounds_for_mode() - 6;
    total = 4 * (rounds_for_mode() + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      w[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
    end
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_double(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r < total / 4; r++) begin
      round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    end
    round_keys_valid = 1'b1;
  endfunction

  // State byte i lives in bits 127-8i down to 120-8i, column major.
  function automatic logic [127:0] substitute(input logic [127:0] s, input bit inv);
    for (int i = 0; i < 16; i++) begin
      s[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
    end
    return s;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input bit inv);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    logic [127:0] t;
    if (inv) begin
      coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[127-8*(4*c+k) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_product(col[k], coef[(k + 4 - r) % 4]);
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] aes_result(input logic req, input logic [127:0] blk);
    int nr;
    if (!round_keys_valid) expand_round_keys();
    nr = rounds_for_mode();
    if (req == REQ_ENCRYPT) begin
      blk ^= round_key[0];
      for (int r = 1; r < nr; r++) begin
        blk = mix_state(rotate_rows(substitute(blk, 0), 0), 0) ^ round_key[r];
      end
      blk = rotate_rows(substitute(blk, 0), 0) ^ round_key[nr];
    end else begin
      blk ^= round_key[nr];
      for (int r = nr - 1; r > 0; r--) begin
        blk = mix_state(substitute(rotate_rows(blk, 1), 1) ^ round_key[r], 1);
      end
      blk = substitute(rotate_rows(blk, 1), 1) ^ round_key[0];
    end
    return blk;
  endfunction

  // Receiver: checks each result transfer and throttles out_ready.
  always @(posedge clk) begin
    int hold_left;
    int holds_seen;
    logic [127:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      holds_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h_%h",
                   $realtime, result_hi, result_lo);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result_hi !== want[127:64]) begin
            $display("%0t: result_hi expected %h actual %h", $realtime, want[127:64], result_hi);
            mismatches++;
          end
          if (result_lo !== want[63:0]) begin
            $display("%0t: result_lo expected %h actual %h", $realtime, want[63:0], result_lo);
            mismatches++;
          end
        end
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Offers one block; returns at the edge where it was transferred, valid still high.
  task automatic send_block(input logic req, input logic [63:0] hi, input logic [63:0] lo);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    req_type <= req;
    data_hi <= hi;
    data_lo <= lo;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(aes_result(req, {hi, lo}));
  endtask

  // The core is back in idle when the last result is transferred; the pause then follows.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_MODE) begin
      if (idx == REG_MODE) mode_reg = val[1:0];
      else key_reg[idx[1:0]] = val;
      round_keys_valid = 1'b0;
    end
  endtask

  task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_MODE, {62'd0, mode});
    cfg_we <= 1'b0;
  endtask

  typedef struct {
    bit          new_key;
    bit          stray_write;
    logic [1:0]  mode;
    logic [63:0] key [4];
    logic        req;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          known;
    logic [127:0] answer;
  } vector_row_t;

  localparam logic [63:0] K0 = 64'h0001020304050607, K1 = 64'h08090a0b0c0d0e0f;
  localparam logic [63:0] K2 = 64'h1011121314151617, K3 = 64'h18191a1b1c1d1e1f;
  localparam logic [63:0] PT_HI = 64'h0011223344556677, PT_LO = 64'h8899aabbccddeeff;
  localparam logic [63:0] ONES = '1;
  localparam logic [127:0] CT_128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [127:0] CT_192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
  localparam logic [127:0] CT_256 = 128'h8ea2b7ca516745bfeafc49904b496089;
  localparam logic [127:0] CT_ZERO = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;

  vector_row_t vectors [] = '{
    // Registers straight from reset: all-zero 128-bit key.
    '{0, 0, MODE_128, '{0, 0, 0, 0}, REQ_ENCRYPT, 0, 0, 1, CT_ZERO},
    '{0, 0, MODE_128, '{0, 0, 0, 0}, REQ_DECRYPT, CT_ZERO[127:64], CT_ZERO[63:0], 1, 0},
    '{1, 0, MODE_128, '{K0, K1, 0, 0}, REQ_ENCRYPT, PT_HI, PT_LO, 1, CT_128},
    '{0, 0, MODE_128, '{K0, K1, 0, 0}, REQ_DECRYPT, CT_128[127:64], CT_128[63:0], 1,
      {PT_HI, PT_LO}},
    '{0, 0, MODE_128, '{K0, K1, 0, 0}, REQ_ENCRYPT, ONES, ONES, 0, 0},
    '{0, 0, MODE_128, '{K0, K1, 0, 0}, REQ_DECRYPT, 0, 0, 0, 0},
    '{1, 0, MODE_192, '{K0, K1, K2, 0}, REQ_ENCRYPT, PT_HI, PT_LO, 1, CT_192},
    '{0, 0, MODE_192, '{K0, K1, K2, 0}, REQ_DECRYPT, CT_192[127:64], CT_192[63:0], 1,
      {PT_HI, PT_LO}},
    '{0, 0, MODE_192, '{K0, K1, K2, 0}, REQ_DECRYPT, ONES, ONES, 0, 0},
    '{1, 0, MODE_256, '{K0, K1, K2, K3}, REQ_ENCRYPT, PT_HI, PT_LO, 1, CT_256},
    '{0, 0, MODE_256, '{K0, K1, K2, K3}, REQ_DECRYPT, CT_256[127:64], CT_256[63:0], 1,
      {PT_HI, PT_LO}},
    // The unused key length code runs as a 256-bit key.
    '{1, 0, MODE_UNUSED, '{K0, K1, K2, K3}, REQ_ENCRYPT, PT_HI, PT_LO, 1, CT_256},
    '{1, 0, MODE_256, '{ONES, ONES, ONES, ONES}, REQ_ENCRYPT, ONES, ONES, 0, 0},
    '{0, 0, MODE_256, '{ONES, ONES, ONES, ONES}, REQ_DECRYPT, ONES, 0, 0, 0},
    // Writes to indexes past the last register must change nothing.
    '{0, 1, MODE_256, '{ONES, ONES, ONES, ONES}, REQ_ENCRYPT, 0, ONES, 0, 0},
    '{0, 1, MODE_256, '{ONES, ONES, ONES, ONES}, REQ_DECRYPT, PT_HI, PT_LO, 0, 0}
  };

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int idle_plan [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{38, 38}};
    logic [63:0] key_word [4];
    logic [63:0] hi, lo;
    foreach (key_reg[i]) key_reg[i] = '0;
    mode_reg = MODE_128;
    round_keys_valid = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[n]) begin
      if (vectors[n].new_key || vectors[n].stray_write) begin
        wait_drained();
        if (vectors[n].new_key) begin
          load_key(vectors[n].mode, vectors[n].key[0], vectors[n].key[1],
                   vectors[n].key[2], vectors[n].key[3]);
        end else begin
          for (int idx = REG_MODE + 1; idx < 8; idx++) begin
            write_reg(3'(idx), {$urandom, $urandom});
          end
          cfg_we <= 1'b0;
        end
      end
      send_block(vectors[n].req, vectors[n].hi, vectors[n].lo);
      if (vectors[n].known) pending_results[$] = vectors[n].answer;
    end

    for (int seg = 0; seg < 16; seg++) begin
      wait_drained();
      send_idle = idle_plan[seg % 4][0];
      recv_stall = idle_plan[seg % 4][1];
      foreach (key_word[i]) begin
        key_word[i] = (seg == 5) ? ONES : (seg == 6) ? 64'd0 : {$urandom, $urandom};
      end
      if (seg % 5 == 4) begin
        // Change one register only; the rest keep their values.
        write_reg(3'($urandom_range(REG_KEY3)), key_word[0]);
        cfg_we <= 1'b0;
      end else begin
        load_key(2'(seg % 4), key_word[0], key_word[1], key_word[2], key_word[3]);
      end
      if (seg == 2) hold_requests++;
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(9))
          0: begin hi = 0; lo = ONES; end
          1: begin hi = ONES; lo = 0; end
          default: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
        endcase
        send_block(1'($urandom_range(1)), hi, lo);
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
